/* design/irse_pkg.sv */
// Package: shared types, word layouts and controller codes for the icon row span extractor.
package irse_pkg;

  localparam int unsigned CoordW = 13;
  localparam int unsigned ScaleW = 8;
  localparam int unsigned ColorW = 16;

  typedef struct packed {
    logic [31:0]        row_bits;
    logic [4:0]         row_index;
    logic [7:0]         origin_x;
    logic [8:0]         origin_y;
    logic [ScaleW-1:0]  scale;
    logic [ColorW-1:0]  color;
  } row_t;

  typedef struct packed {
    logic [CoordW-1:0]  span_x;
    logic [CoordW-1:0]  span_y;
    logic [CoordW-1:0]  span_width;
    logic [ScaleW-1:0]  span_height;
    logic [ColorW-1:0]  span_color;
    logic               last_span;
  } span_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // take the input word into the run scanner
    logic step;   // extract the lowest remaining run into the span stage
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic load_has_run;  // incoming word will yield at least one span
    logic step_last;     // run being extracted now is the row's last
    logic stage_free;    // span stage can take a run this cycle
  } sts_t;

endpackage

/* design/irse_chan_if.sv */
// Interface: valid/ready channel carrying one word of a given payload type.
interface irse_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/irse_ctrl.sv */
// Controller: row accept and run extraction sequencing.
module irse_ctrl
  import irse_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && sts_i.load_has_run) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = sts_i.stage_free;
        if (sts_i.stage_free && sts_i.step_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/irse_dp.sv */
// Datapath: run scanner, span stage and span output register.
module irse_dp
  import irse_pkg::*;
#(
  parameter int unsigned ROW_PIXELS = 32,
  parameter int unsigned ICON_ROWS  = 19
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  output sts_t  sts_o,
  input  row_t  row_i,
  output logic  span_valid_o,
  input  logic  span_ready_i,
  output span_t span_o
);

  localparam int unsigned CW = $clog2(ROW_PIXELS + 1);

  function automatic logic [CW-1:0] enc(input logic [ROW_PIXELS:0] v);
    logic [CW-1:0] r;
    r = '0;
    for (int i = 0; i <= ROW_PIXELS; i++) begin
      if (v[i]) r = r | CW'(i);
    end
    return r;
  endfunction

  // remaining pixels, column c at bit c
  logic [ROW_PIXELS-1:0] x_q, x_d;

  logic [7:0]        ox_q;
  logic [8:0]        oy_q;
  logic [4:0]        row_q;
  logic [ScaleW-1:0] sc_q;
  logic [ColorW-1:0] col_q;

  logic              s1v_q, s1v_d;
  logic [CW-1:0]     s1_start_q, s1_len_q;
  logic              s1_last_q;
  logic [7:0]        s1_ox_q;
  logic [8:0]        s1_oy_q;
  logic [4:0]        s1_row_q;
  logic [ScaleW-1:0] s1_sc_q;
  logic [ColorW-1:0] s1_col_q;

  logic              ov_q, ov_d;
  span_t             span_q, span_d;

  logic [63:0]           bits64;
  logic [ROW_PIXELS-1:0] colword;
  logic                  load_ok;
  logic [ROW_PIXELS-1:0] lsb;
  logic [ROW_PIXELS:0]   sum;
  logic [ROW_PIXELS:0]   endhot;
  logic [ROW_PIXELS-1:0] x_next;
  logic [CW-1:0]         run_start, run_end;
  logic                  out_take;

  // bit order flip: leftmost pixel becomes bit 0
  always_comb begin
    bits64 = {32'b0, row_i.row_bits};
    for (int i = 0; i < int'(ROW_PIXELS); i++) begin
      colword[i] = bits64[int'(ROW_PIXELS) - 1 - i];
    end
  end

  assign load_ok = (7'(row_i.row_index) < 7'(ICON_ROWS)) && (row_i.scale != '0) &&
                   (colword != '0);

  // lowest run: adding its lowest bit carries through the run to the column past it
  assign lsb       = x_q & (~x_q + ROW_PIXELS'(1));
  assign sum       = {1'b0, x_q} + {1'b0, lsb};
  assign endhot    = sum & ~{1'b0, x_q};
  assign x_next    = x_q & sum[ROW_PIXELS-1:0];
  assign run_start = enc({1'b0, lsb});
  assign run_end   = enc(endhot);

  assign out_take = !ov_q || span_ready_i;

  assign sts_o.load_has_run = load_ok;
  assign sts_o.step_last    = (x_next == '0);
  assign sts_o.stage_free   = !s1v_q || out_take;

  always_comb begin
    x_d = x_q;
    if (cmd_i.load) begin
      x_d = load_ok ? colword : '0;
    end else if (cmd_i.step) begin
      x_d = x_next;
    end
  end

  always_comb begin
    s1v_d = s1v_q;
    if (cmd_i.step) begin
      s1v_d = 1'b1;
    end else if (out_take) begin
      s1v_d = 1'b0;
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (out_take) ov_d = s1v_q;
    span_d.span_x      = CoordW'(s1_ox_q) + CoordW'(s1_start_q) * CoordW'(s1_sc_q);
    span_d.span_y      = CoordW'(s1_oy_q) + CoordW'(s1_row_q) * CoordW'(s1_sc_q);
    span_d.span_width  = CoordW'(s1_len_q) * CoordW'(s1_sc_q);
    span_d.span_height = s1_sc_q;
    span_d.span_color  = s1_col_q;
    span_d.last_span   = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      s1v_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      x_q   <= x_d;
      s1v_q <= s1v_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ox_q  <= row_i.origin_x;
      oy_q  <= row_i.origin_y;
      row_q <= row_i.row_index;
      sc_q  <= row_i.scale;
      col_q <= row_i.color;
    end
    if (cmd_i.step) begin
      s1_start_q <= run_start;
      s1_len_q   <= run_end - run_start;
      s1_last_q  <= (x_next == '0);
      s1_ox_q    <= ox_q;
      s1_oy_q    <= oy_q;
      s1_row_q   <= row_q;
      s1_sc_q    <= sc_q;
      s1_col_q   <= col_q;
    end
    if (out_take && s1v_q) begin
      span_q <= span_d;
    end
  end

  assign span_valid_o = ov_q;
  assign span_o       = span_q;

`ifndef SYNTHESIS
  a_step_has_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (x_q != '0))
    else $error("run extraction with no pixels left");

  a_load_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (x_q == '0) && !cmd_i.step)
    else $error("new row loaded while runs remain");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1v_q && ov_q && !span_ready_i) |=> s1v_q && $stable(s1_start_q) && $stable(s1_len_q))
    else $error("span stage lost a run under stall");

  a_height_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (span_q.span_height != '0))
    else $error("span word with zero height");
`endif

endmodule

/* design/icon_row_span_extractor.sv */
// Top level: icon row to filled-rectangle span extractor.
//
//   channel  dir  modport  word
//   row_i    in   sink     one icon row: pixels, row index, origin, scale, color
//   span_o   out  source   one rectangle: x, y, width, height, color, last flag
//
// A row is accepted, then its runs leave one per cycle, left to right, while span_o
// does not stall: a row holds at most ROW_PIXELS/2 runs, and the run scanner extracts
// one run per cycle while the span stage is free. Rows with no span yield no span word.
// A span passes a span stage and then an output register; the next row is accepted
// while those still drain.
// Reset (rst_ni, asynchronous, active low) empties scanner and both stages.
// A stalled span_o holds the output word and backs up into the scanner.
module icon_row_span_extractor
  import irse_pkg::*;
#(
  parameter int unsigned ROW_PIXELS = 32,
  parameter int unsigned ICON_ROWS  = 19
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  irse_chan_if.sink   row_i,
  irse_chan_if.source span_o
);

  cmd_t cmd;
  sts_t sts;

  irse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (row_i.valid),
    .in_ready_o (row_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  irse_dp #(
    .ROW_PIXELS (ROW_PIXELS),
    .ICON_ROWS  (ICON_ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .row_i        (row_i.data),
    .span_valid_o (span_o.valid),
    .span_ready_i (span_o.ready),
    .span_o       (span_o.data)
  );

endmodule
